FILE: hdl/mhbe_pkg.sv
// Package for the multi-histogram binning engine: sizes, codes and storage layouts.
`default_nettype none
package mhbe_pkg;

  localparam int HIST_COUNT   = 64;
  localparam int HIST_ID_W    = 6;
  localparam int STORE_DEPTH  = 4096;
  localparam int SLOT_W       = $clog2(STORE_DEPTH);
  localparam int FREE_W       = SLOT_W + 1;
  localparam int DEFAULT_BINS = 50;
  localparam int DIV_STEPS    = 35;
  localparam int STEP_W       = $clog2(DIV_STEPS + 1);

  localparam logic [62:0] SQ_MAX = {63{1'b1}};

  typedef enum logic [2:0] {
    CMD_DEFINE     = 3'd0,
    CMD_ACCUMULATE = 3'd1,
    CMD_READ_BIN   = 3'd2,
    CMD_READ_MOM   = 3'd3,
    CMD_RESET_ALL  = 3'd4
  } mhbe_cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_ID    = 3'd1,
    STAT_UNDEFINED = 3'd2,
    STAT_DEFINED   = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_BOUNDS    = 3'd5,
    STAT_BAD_BIN   = 3'd6
  } mhbe_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_PREP, S_DIV, S_BIN, S_ACC, S_RBIN, S_CLEAR, S_RESP
  } mhbe_state_e;

  typedef struct packed {
    logic        [SLOT_W-1:0] base;
    logic        [9:0]        total;
    logic signed [23:0]       low;
    logic signed [24:0]       span;
  } mhbe_cfg_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic        [62:0] sq;
  } mhbe_mom_t;

endpackage
`default_nettype wire

FILE: hdl/multi_histogram_binning_engine.sv
// Top level of the multi-histogram binning engine.
// One request is taken at a time; a finished response waits in an output register while the
// next request is already accepted. Define clears its n + 2 bins in the count memory, one per
// cycle; accumulate runs the restoring divider (one quotient bit per cycle over 35 steps), then
// a read-modify-write of the bin; read bin reads one count; read moments, reset all and every
// rejected request answer straight from the lookup. The per-histogram descriptor and moment
// sums share one 64-entry memory, the bin counts sit in a 4096-entry memory; both are read
// through a register. Reset all frees every histogram at once and costs no clearing pass.
`default_nettype none
module multi_histogram_binning_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          command_i,
  input  wire logic [5:0]          histogram_id_i,
  input  wire logic signed [23:0]  sample_value_i,
  input  wire logic [15:0]         weight_i,
  input  wire logic signed [23:0]  lower_edge_i,
  input  wire logic signed [23:0]  upper_edge_i,
  input  wire logic [9:0]          bins_requested_i,
  input  wire logic [10:0]         bin_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               status_o,
  output logic [31:0]              bin_content_o,
  output logic signed [63:0]       moment_sum_o,
  output logic [62:0]              moment_squares_o
);

  localparam int SW = mhbe_pkg::SLOT_W;
  localparam int HW = $bits(mhbe_pkg::mhbe_cfg_t) + $bits(mhbe_pkg::mhbe_mom_t);

  mhbe_pkg::mhbe_state_e state_q, state_d;

  // latched request
  mhbe_pkg::mhbe_cmd_e cmd_q;
  logic [5:0]          id_q;
  logic signed [23:0]  x_q, lo_q, hi_q;
  logic [15:0]         w_q;
  logic [9:0]          req_q;
  logic [10:0]         bidx_q;

  // memories
  logic [HW-1:0]       hist_mem [mhbe_pkg::HIST_COUNT];
  logic [31:0]         cnt_mem [mhbe_pkg::STORE_DEPTH];
  mhbe_pkg::mhbe_cfg_t cfg_rd_q;
  mhbe_pkg::mhbe_mom_t mom_rd_q;
  logic [31:0]         cnt_rd_q;

  logic [mhbe_pkg::HIST_COUNT-1:0] mark_q;
  logic [mhbe_pkg::FREE_W-1:0]     free_q;

  // arithmetic
  logic signed [35:0] num_q;
  logic signed [40:0] xw_q;
  logic [47:0]        sqx_q;
  logic [63:0]        p_q;
  logic [34:0]        dvd_q;
  logic [23:0]        dsr_q;
  logic [23:0]        rem_q;
  logic               neg_q;
  logic [mhbe_pkg::STEP_W-1:0] step_q;

  // clearing sweep
  logic [SW-1:0] clr_ptr_q;
  logic [10:0]   clr_cnt_q;

  // staged response and output register
  logic [2:0]         res_st_q;
  logic [31:0]        res_cnt_q;
  logic signed [63:0] res_sum_q;
  logic [62:0]        res_sq_q;
  logic               out_valid_q;

  logic in_fire;
  assign in_ready_o = (state_q == mhbe_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // decode of the looked-up descriptor
  logic        id_bad, is_def;
  logic [9:0]  n_def;
  logic        full;
  logic signed [24:0] span_new, diff;
  logic [23:0] ax;
  assign id_bad   = {3'b000, id_q} >= 9'(mhbe_pkg::HIST_COUNT);
  assign is_def   = mark_q[id_q];
  assign n_def    = (req_q == 10'd0) ? 10'(mhbe_pkg::DEFAULT_BINS) : req_q;
  assign full     = ({1'b0, free_q} + 14'(n_def) + 14'd2) > 14'(mhbe_pkg::STORE_DEPTH);
  assign span_new = $signed({hi_q[23], hi_q}) - $signed({lo_q[23], lo_q});
  assign diff     = $signed({x_q[23], x_q}) - $signed({cfg_rd_q.low[23], cfg_rd_q.low});
  assign ax       = x_q[23] ? 24'(-x_q) : 24'(x_q);

  // divider step
  logic [24:0] trial;
  logic        qbit;
  assign trial = {rem_q, dvd_q[34]};
  assign qbit  = trial >= {1'b0, dsr_q};

  // floor quotient and bin clamp
  logic signed [35:0] qs;
  logic [10:0]        bin;
  always_comb begin
    qs = neg_q ? (-$signed({1'b0, dvd_q}) - 36'(rem_q != 24'd0)) : $signed({1'b0, dvd_q});
    if (qs < -36'sd1) bin = 11'd0;
    else if (qs >= $signed({26'd0, cfg_rd_q.total})) bin = 11'(cfg_rd_q.total) + 11'd1;
    else bin = 11'(qs + 36'sd1);
  end

  // saturating updates
  logic signed [64:0] sum_ext;
  logic [63:0]        sq_ext;
  logic [32:0]        cnt_ext;
  logic signed [63:0] sum_new;
  logic [62:0]        sq_new;
  logic [31:0]        cnt_new;
  always_comb begin
    sum_ext = $signed({mom_rd_q.sum[63], mom_rd_q.sum}) + 65'(xw_q);
    if (sum_ext[64] != sum_ext[63]) sum_new = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sum_new = sum_ext[63:0];
    sq_ext  = {1'b0, mom_rd_q.sq} + p_q;
    sq_new  = sq_ext[63] ? mhbe_pkg::SQ_MAX : sq_ext[62:0];
    cnt_ext = {1'b0, cnt_rd_q} + 33'(w_q);
    cnt_new = cnt_ext[32] ? 32'hFFFF_FFFF : cnt_ext[31:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mhbe_pkg::S_IDLE: if (in_fire) state_d = mhbe_pkg::S_LOOK;
      mhbe_pkg::S_LOOK: begin
        state_d = mhbe_pkg::S_RESP;
        if (cmd_q <= mhbe_pkg::CMD_READ_MOM && !id_bad) begin
          if (cmd_q == mhbe_pkg::CMD_DEFINE) begin
            if (!is_def && !full && span_new != 25'sd0) state_d = mhbe_pkg::S_CLEAR;
          end else if (is_def) begin
            if (cmd_q == mhbe_pkg::CMD_ACCUMULATE) state_d = mhbe_pkg::S_PREP;
            else if (cmd_q == mhbe_pkg::CMD_READ_BIN &&
                     12'(bidx_q) <= 12'(cfg_rd_q.total) + 12'd1) state_d = mhbe_pkg::S_RBIN;
          end
        end
      end
      mhbe_pkg::S_PREP:  state_d = mhbe_pkg::S_DIV;
      mhbe_pkg::S_DIV:   if (step_q == mhbe_pkg::STEP_W'(1)) state_d = mhbe_pkg::S_BIN;
      mhbe_pkg::S_BIN:   state_d = mhbe_pkg::S_ACC;
      mhbe_pkg::S_ACC:   state_d = mhbe_pkg::S_RESP;
      mhbe_pkg::S_RBIN:  state_d = mhbe_pkg::S_RESP;
      mhbe_pkg::S_CLEAR: if (clr_cnt_q == 11'd1) state_d = mhbe_pkg::S_RESP;
      mhbe_pkg::S_RESP:  if (!out_valid_q || out_ready_i) state_d = mhbe_pkg::S_IDLE;
      default:           state_d = mhbe_pkg::S_IDLE;
    endcase
  end

  // memory controls
  logic          cnt_re, cnt_we, hist_we;
  logic [SW-1:0] cnt_raddr, cnt_waddr;
  logic [31:0]   cnt_wdata;
  mhbe_pkg::mhbe_cfg_t cfg_wdata;
  mhbe_pkg::mhbe_mom_t mom_wdata;
  always_comb begin
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    hist_we   = 1'b0;
    cnt_raddr = cfg_rd_q.base + SW'(bin);
    cnt_waddr = clr_ptr_q;
    cnt_wdata = 32'd0;
    cfg_wdata = cfg_rd_q;
    mom_wdata = '0;
    case (state_q)
      mhbe_pkg::S_LOOK: begin
        if (state_d == mhbe_pkg::S_CLEAR) begin
          // fresh descriptor, moment sums start from zero
          hist_we   = 1'b1;
          cfg_wdata = '{base: free_q[SW-1:0], total: n_def, low: lo_q, span: span_new};
        end
        if (state_d == mhbe_pkg::S_RBIN) begin
          cnt_re    = 1'b1;
          cnt_raddr = cfg_rd_q.base + SW'(bidx_q);
        end
      end
      mhbe_pkg::S_BIN: cnt_re = 1'b1;
      mhbe_pkg::S_ACC: begin
        cnt_we    = 1'b1;
        cnt_waddr = cnt_raddr;
        cnt_wdata = cnt_new;
        hist_we   = 1'b1;
        mom_wdata = '{sum: sum_new, sq: sq_new};
      end
      mhbe_pkg::S_CLEAR: cnt_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) {cfg_rd_q, mom_rd_q} <= hist_mem[histogram_id_i];
    if (hist_we) hist_mem[id_q] <= {cfg_wdata, mom_wdata};
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_raddr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= mhbe_pkg::mhbe_cmd_e'(command_i);
      id_q   <= histogram_id_i;
      x_q    <= sample_value_i;
      w_q    <= weight_i;
      lo_q   <= lower_edge_i;
      hi_q   <= upper_edge_i;
      req_q  <= bins_requested_i;
      bidx_q <= bin_index_i;
    end
    case (state_q)
      mhbe_pkg::S_LOOK: begin
        num_q     <= $signed({1'b0, cfg_rd_q.total}) * diff;
        xw_q      <= x_q * $signed({1'b0, w_q});
        sqx_q     <= ax * ax;
        clr_ptr_q <= free_q[SW-1:0];
        clr_cnt_q <= 11'(n_def) + 11'd2;
        res_st_q  <= mhbe_pkg::STAT_OK;
        res_cnt_q <= 32'd0;
        res_sum_q <= 64'sd0;
        res_sq_q  <= 63'd0;
        if (cmd_q <= mhbe_pkg::CMD_READ_MOM) begin
          if (id_bad) res_st_q <= mhbe_pkg::STAT_BAD_ID;
          else if (cmd_q == mhbe_pkg::CMD_DEFINE) begin
            if (is_def) res_st_q <= mhbe_pkg::STAT_DEFINED;
            else if (full) res_st_q <= mhbe_pkg::STAT_FULL;
            else if (span_new == 25'sd0) res_st_q <= mhbe_pkg::STAT_BOUNDS;
          end else if (!is_def) res_st_q <= mhbe_pkg::STAT_UNDEFINED;
          else if (cmd_q == mhbe_pkg::CMD_READ_BIN) begin
            if (12'(bidx_q) > 12'(cfg_rd_q.total) + 12'd1) res_st_q <= mhbe_pkg::STAT_BAD_BIN;
          end else if (cmd_q == mhbe_pkg::CMD_READ_MOM) begin
            res_sum_q <= mom_rd_q.sum;
            res_sq_q  <= mom_rd_q.sq;
          end
        end
      end
      mhbe_pkg::S_PREP: begin
        dvd_q  <= num_q[35] ? 35'(-num_q) : 35'(num_q);
        dsr_q  <= cfg_rd_q.span[24] ? 24'(-cfg_rd_q.span) : 24'(cfg_rd_q.span);
        rem_q  <= 24'd0;
        neg_q  <= num_q[35] ^ cfg_rd_q.span[24];
        step_q <= mhbe_pkg::STEP_W'(mhbe_pkg::DIV_STEPS);
        p_q    <= sqx_q * w_q;
      end
      mhbe_pkg::S_DIV: begin
        rem_q  <= qbit ? 24'(trial - {1'b0, dsr_q}) : trial[23:0];
        dvd_q  <= {dvd_q[33:0], qbit};
        step_q <= step_q - mhbe_pkg::STEP_W'(1);
      end
      mhbe_pkg::S_RBIN: res_cnt_q <= cnt_rd_q;
      mhbe_pkg::S_CLEAR: begin
        clr_ptr_q <= clr_ptr_q + SW'(1);
        clr_cnt_q <= clr_cnt_q - 11'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhbe_pkg::S_IDLE;
      mark_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mhbe_pkg::S_LOOK) begin
        if (cmd_q == mhbe_pkg::CMD_RESET_ALL) begin
          mark_q <= '0;
          free_q <= '0;
        end else if (state_d == mhbe_pkg::S_CLEAR) begin
          // claim the bins now; the sweep clears them behind
          mark_q[id_q] <= 1'b1;
          free_q       <= free_q + mhbe_pkg::FREE_W'(n_def) + mhbe_pkg::FREE_W'(2);
        end
      end
      // hold an unaccepted response, load a new one from the response state
      out_valid_q <= (out_valid_q && !out_ready_i) ||
                     (state_q == mhbe_pkg::S_RESP && (!out_valid_q || out_ready_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mhbe_pkg::S_RESP && (!out_valid_q || out_ready_i)) begin
      status_o         <= res_st_q;
      bin_content_o    <= res_cnt_q;
      moment_sum_o     <= res_sum_q;
      moment_squares_o <= res_sq_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_clear_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mhbe_pkg::S_CLEAR |-> clr_cnt_q != 11'd0) else $error("empty clear sweep");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= mhbe_pkg::FREE_W'(mhbe_pkg::STORE_DEPTH)) else $error("store overrun");
  a_acc_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mhbe_pkg::S_ACC |-> $past(state_q) == mhbe_pkg::S_BIN)
    else $error("bin update without read");
  a_resp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mhbe_pkg::S_RESP)
    else $error("response from wrong state");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for the multi-histogram binning engine: random and directed requests.
`default_nettype none
module tb;

  localparam int NBINS_CAP = 1023;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         id;
    logic signed [23:0] x;
    logic [15:0]        w;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic [9:0]         req;
    logic [10:0]        bidx;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        content;
    logic signed [63:0] msum;
    logic [62:0]        msq;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  request_t drv = '0;
  logic [2:0] status;
  logic [31:0] content;
  logic signed [63:0] msum;
  logic [62:0] msq;

  always #4 clk = ~clk;

  multi_histogram_binning_engine i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(drv.cmd), .histogram_id_i(drv.id), .sample_value_i(drv.x),
    .weight_i(drv.w), .lower_edge_i(drv.lo), .upper_edge_i(drv.hi),
    .bins_requested_i(drv.req), .bin_index_i(drv.bidx),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .bin_content_o(content),
    .moment_sum_o(msum), .moment_squares_o(msq)
  );

  // Shadow of the engine state
  logic               hist_defined [mhbe_pkg::HIST_COUNT];
  int unsigned        hist_base    [mhbe_pkg::HIST_COUNT];
  int unsigned        hist_nbins   [mhbe_pkg::HIST_COUNT];
  longint             hist_low     [mhbe_pkg::HIST_COUNT];
  longint             hist_span    [mhbe_pkg::HIST_COUNT];
  longint             hist_sum     [mhbe_pkg::HIST_COUNT];
  longint unsigned    hist_sq      [mhbe_pkg::HIST_COUNT];
  longint unsigned    bin_counts   [mhbe_pkg::STORE_DEPTH];
  int unsigned        free_slot;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       n_fail = 0;
  int       idle_in_pct = 0;
  int       idle_out_pct = 0;
  bit       hold_sink = 1'b0;

  // Floored bin number 0..n+1; mirrors for a negative span
  function automatic int unsigned bin_of(int unsigned h, longint x);
    longint n, num, q, r;
    n   = hist_nbins[h];
    num = n * (x - hist_low[h]);
    q   = num / hist_span[h];
    r   = num % hist_span[h];
    if (r != 0 && ((r < 0) != (hist_span[h] < 0))) q--;
    if (q < -1) return 0;
    if (q >= n) return 32'(n + 1);
    return 32'(q + 1);
  endfunction

  function automatic answer_t predict_answer(request_t rq);
    answer_t a;
    int unsigned n, slot;
    longint x, prod;
    longint unsigned p, ax;
    a = '0;
    x = rq.x;
    if (rq.cmd == mhbe_pkg::CMD_RESET_ALL) begin
      foreach (hist_defined[i]) hist_defined[i] = 1'b0;
      free_slot = 0;
    end else if (rq.cmd <= mhbe_pkg::CMD_READ_MOM) begin
      if (rq.cmd == mhbe_pkg::CMD_DEFINE) begin
        n = (rq.req != 0) ? rq.req : mhbe_pkg::DEFAULT_BINS;
        if (hist_defined[rq.id]) a.status = mhbe_pkg::STAT_DEFINED;
        else if (free_slot + n + 2 > mhbe_pkg::STORE_DEPTH) a.status = mhbe_pkg::STAT_FULL;
        else if (rq.lo == rq.hi) a.status = mhbe_pkg::STAT_BOUNDS;
        else begin
          hist_defined[rq.id] = 1'b1;
          hist_base[rq.id]    = free_slot;
          hist_nbins[rq.id]   = n;
          hist_low[rq.id]     = rq.lo;
          hist_span[rq.id]    = longint'(rq.hi) - longint'(rq.lo);
          hist_sum[rq.id]     = 0;
          hist_sq[rq.id]      = 0;
          for (int unsigned i = 0; i < n + 2; i++) bin_counts[free_slot + i] = 0;
          free_slot += n + 2;
        end
      end else if (!hist_defined[rq.id]) begin
        a.status = mhbe_pkg::STAT_UNDEFINED;
      end else if (rq.cmd == mhbe_pkg::CMD_ACCUMULATE) begin
        slot = (hist_base[rq.id] + bin_of(rq.id, x)) % mhbe_pkg::STORE_DEPTH;
        bin_counts[slot] += rq.w;
        if (bin_counts[slot] > 64'hFFFF_FFFF) bin_counts[slot] = 64'hFFFF_FFFF;
        prod = x * longint'(rq.w);
        if (prod > 0 && hist_sum[rq.id] > 64'sh7FFF_FFFF_FFFF_FFFF - prod)
          hist_sum[rq.id] = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (prod < 0 && hist_sum[rq.id] < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - prod)
          hist_sum[rq.id] = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else hist_sum[rq.id] += prod;
        ax = (x < 0) ? -x : x;
        p  = ax * ax * rq.w;
        if (hist_sq[rq.id] > 64'h7FFF_FFFF_FFFF_FFFF - p) hist_sq[rq.id] = 64'h7FFF_FFFF_FFFF_FFFF;
        else hist_sq[rq.id] += p;
      end else if (rq.cmd == mhbe_pkg::CMD_READ_BIN) begin
        if (rq.bidx > hist_nbins[rq.id] + 1) a.status = mhbe_pkg::STAT_BAD_BIN;
        else a.content = 32'(bin_counts[(hist_base[rq.id] + rq.bidx) % mhbe_pkg::STORE_DEPTH]);
      end else begin
        a.msum = hist_sum[rq.id];
        a.msq  = hist_sq[rq.id][62:0];
      end
    end
    return a;
  endfunction

  // Driver: hold valid and payload until the request is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99, 0) >= idle_in_pct) begin
          drv <= pending_requests[0];
          expected_answers.push_back(predict_answer(pending_requests[0]));
          void'(pending_requests.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink stall and response checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n) begin
      out_ready <= !hold_sink && ($urandom_range(99, 0) >= idle_out_pct);
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("response with no request outstanding");
          n_fail++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (status !== exp_a.status) begin
            $error("status exp %0d got %0d", exp_a.status, status); n_fail++;
          end
          if (content !== exp_a.content) begin
            $error("bin_content exp %0d got %0d", exp_a.content, content); n_fail++;
          end
          if (msum !== exp_a.msum) begin
            $error("moment_sum exp %0d got %0d", exp_a.msum, msum); n_fail++;
          end
          if (msq !== exp_a.msq) begin
            $error("moment_squares exp %0d got %0d", exp_a.msq, msq); n_fail++;
          end
        end
      end
    end
  end

  function automatic request_t blank_req(logic [2:0] c, logic [5:0] h);
    request_t r;
    r = '0;
    r.cmd = c;
    r.id  = h;
    return r;
  endfunction

  task automatic push_define(logic [5:0] h, int lo, int hi, int n);
    request_t r;
    r = blank_req(mhbe_pkg::CMD_DEFINE, h);
    r.lo = 24'(lo); r.hi = 24'(hi); r.req = 10'(n);
    pending_requests.push_back(r);
  endtask

  task automatic push_sample(logic [5:0] h, int x, int w);
    request_t r;
    r = blank_req(mhbe_pkg::CMD_ACCUMULATE, h);
    r.x = 24'(x); r.w = 16'(w);
    pending_requests.push_back(r);
  endtask

  task automatic push_read(logic [5:0] h, int b);
    request_t r;
    r = blank_req(mhbe_pkg::CMD_READ_BIN, h);
    r.bidx = 11'(b);
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    @(posedge clk);
  endtask

  // One random request, aimed at the histograms below nhist
  function automatic request_t random_req(int unsigned nhist);
    request_t r;
    int sel;
    r    = '0;
    r.id = 6'($urandom_range(nhist - 1, 0));
    r.x  = 24'($urandom);
    r.w  = 16'($urandom);
    r.lo = 24'($urandom);
    r.hi = 24'($urandom);
    r.req = 10'($urandom_range(3, 0) == 0 ? $urandom : $urandom_range(12, 0));
    r.bidx = 11'($urandom_range(9, 0) == 0 ? $urandom : $urandom_range(14, 0));
    if ($urandom_range(3, 0) == 0) r.x = 24'($urandom_range(40, 0) - 20);
    if ($urandom_range(7, 0) == 0) r.w = 16'hFFFF;
    sel = $urandom_range(99, 0);
    if (sel < 45) r.cmd = mhbe_pkg::CMD_ACCUMULATE;
    else if (sel < 65) r.cmd = mhbe_pkg::CMD_READ_BIN;
    else if (sel < 78) r.cmd = mhbe_pkg::CMD_READ_MOM;
    else if (sel < 93) r.cmd = mhbe_pkg::CMD_DEFINE;
    else if (sel < 95) r.cmd = mhbe_pkg::CMD_RESET_ALL;
    else r.cmd = 3'($urandom_range(7, 5));
    if (r.cmd == mhbe_pkg::CMD_DEFINE && $urandom_range(1, 0) == 0) begin
      r.lo = 24'($urandom_range(40, 0) - 20);
      r.hi = 24'(r.lo + $urandom_range(30, 1) * ($urandom_range(3, 0) == 0 ? -1 : 1));
    end
    return r;
  endfunction

  initial begin
    request_t r;
    foreach (hist_defined[i]) hist_defined[i] = 1'b0;
    free_slot = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: errors, extremes, mirrored range, store full
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_READ_BIN, 6'd3));
    push_define(6'd0, -8388608, 8388607, 0);
    push_define(6'd0, 0, 10, 4);
    push_define(6'd1, 5, 5, 4);
    push_define(6'd2, 10, -10, 4);
    push_sample(6'd0, -8388608, 65535);
    push_sample(6'd0, 8388607, 65535);
    push_sample(6'd0, 0, 0);
    push_sample(6'd2, 9, 1);
    push_sample(6'd2, -11, 2);
    push_sample(6'd2, 10, 3);
    push_read(6'd0, 0);
    push_read(6'd0, 51);
    push_read(6'd0, 52);
    push_read(6'd2, 1);
    push_read(6'd2, 5);
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_READ_MOM, 6'd0));
    pending_requests.push_back(blank_req(3'd7, 6'd63));
    push_define(6'd63, 0, 1, NBINS_CAP);
    push_define(6'd62, 0, 1, NBINS_CAP);
    push_define(6'd61, 0, 1, NBINS_CAP);
    push_define(6'd60, 0, 1, NBINS_CAP);
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_RESET_ALL, 6'd0));
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_READ_MOM, 6'd0));
    drain();

    // Saturation of the squares sum
    push_define(6'd5, -100, 100, 1);
    repeat (4) begin
      r = blank_req(mhbe_pkg::CMD_ACCUMULATE, 6'd5);
      r.x = -24'sd8388608; r.w = 16'hFFFF;
      pending_requests.push_back(r);
    end
    push_read(6'd5, 0);
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_READ_MOM, 6'd5));
    drain();

    // Receiver holds off long while the sender keeps offering
    hold_sink = 1'b1;
    for (int i = 0; i < 12; i++) push_sample(6'd5, i, i);
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
    drain();
    pending_requests.push_back(blank_req(mhbe_pkg::CMD_RESET_ALL, 6'd0));

    for (int phase = 0; phase < 3; phase++) begin
      idle_in_pct  = (phase == 0) ? 18 : (phase == 1) ? 76 : 0;
      idle_out_pct = (phase == 0) ? 76 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < 340; i++) begin
        pending_requests.push_back(random_req(phase == 2 ? 64 : 12));
        if (pending_requests.size() > 16) wait (pending_requests.size() < 4);
      end
      drain();
    end
    repeat (200) @(posedge clk);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
